FILE: rtl/dti_sa_pkg.sv
// Shared constants, table types and elaboration-time exponential tables.
`default_nettype none

package dti_sa_pkg;

  localparam int EXP_TABLE_DEPTH = 256;
  localparam int EXP_INT_SPAN    = 32;
  localparam int SERIES_TERMS    = 20;

  localparam int TAB_IDX_W = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int INT_IDX_W = $clog2(EXP_INT_SPAN);
  localparam int POS_W     = 16 + TAB_IDX_W;
  localparam int X_W       = 16 + INT_IDX_W;

  localparam int Q_W  = 56;
  localparam int QS_W = Q_W - 12;
  localparam int BV_W = 15;
  localparam int P_W  = QS_W + BV_W;
  localparam int A_W  = 34;
  localparam int SP_W = A_W + 16;

  // Pipeline layout
  localparam int NUM_STAGES  = 15;
  localparam int NEXP_FIRST  = 4;
  localparam int NEXP_STAGES = 9;
  localparam int NEG_STAGE   = 3;
  localparam int MUL_STAGE   = NEXP_FIRST + NEXP_STAGES;

  // Divide by 1e6: reciprocal estimate plus up to two corrections
  localparam logic [19:0] B_SCALE     = 20'd1000000;
  localparam logic [21:0] B_SCALE_X2  = 22'd2000000;
  localparam int          H_LSB       = 19;
  localparam int          H_W         = 22;
  localparam int          PLOW_W      = H_LSB + H_W;
  localparam int          HM_W        = 2 * H_W;
  localparam int          T_W         = H_W + 20;
  localparam logic [H_W-1:0] RECIP    = H_W'((64'd1 << PLOW_W) / 64'd1000000);
  localparam logic [P_W-1:0] EXP_LIMIT =
    P_W'(64'(EXP_INT_SPAN) * 64'd65536 * 64'd1000000);

  // Config
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = BV_W;
  localparam logic [CFG_IDX_W-1:0] REG_B_VALUE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_BY_B0 = CFG_IDX_W'(1);
  localparam logic [BV_W-1:0]      B_VALUE_RESET   = BV_W'(1000);

  typedef logic [31:0] frac_tab_t [EXP_TABLE_DEPTH+1];
  typedef logic [31:0] int_tab_t  [EXP_INT_SPAN];

  // Shift-subtract quotient, used only while building the tables
  function automatic logic [63:0] cdiv(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] part;
    quo  = '0;
    part = '0;
    for (int bi = 63; bi >= 0; bi--) begin
      part = {part[63:0], num[bi]};
      if (part >= {1'b0, den}) begin
        part    = part - {1'b0, den};
        quo[bi] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic frac_tab_t build_frac_tab();
    frac_tab_t         tab;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        rounded;
    for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
      term = 64'd1 << 48;
      sum  = $signed(term);
      for (int i = 1; i <= SERIES_TERMS; i++) begin
        term = cdiv(term * 64'(k), 64'(EXP_TABLE_DEPTH) * 64'(i));
        if ((i & 1) == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      rounded = ($unsigned(sum) + (64'd1 << 16)) >> 17;
      tab[k]  = rounded[31:0];
    end
    return tab;
  endfunction

  localparam frac_tab_t FRAC_TAB = build_frac_tab();

  function automatic int_tab_t build_int_tab();
    int_tab_t    tab;
    logic [63:0] prod;
    tab[0] = 32'h8000_0000;
    for (int i = 1; i < EXP_INT_SPAN; i++) begin
      prod   = (64'(tab[i-1]) * 64'(FRAC_TAB[EXP_TABLE_DEPTH]) + (64'd1 << 30)) >> 31;
      tab[i] = prod[31:0];
    end
    return tab;
  endfunction

  localparam int_tab_t INT_TAB = build_int_tab();

endpackage

`default_nettype wire

FILE: rtl/dti_sa_nexp.sv
// Pipelined exp(-b*q): scale by b-value, divide by 1e6, table lookup and interpolate.
`default_nettype none

module dti_sa_nexp (
  input  wire logic                              clk,
  input  wire logic [dti_sa_pkg::NEXP_STAGES-1:0] stage_en,
  input  wire logic [dti_sa_pkg::QS_W-1:0]        qs,
  input  wire logic [dti_sa_pkg::BV_W-1:0]        b_value,
  output logic      [dti_sa_pkg::A_W-1:0]         atten
);

  logic [dti_sa_pkg::P_W-1:0]    p_r;
  logic [dti_sa_pkg::PLOW_W-1:0] plow1_r, plow2_r;
  logic [dti_sa_pkg::HM_W-1:0]   hm_r;
  logic [dti_sa_pkg::H_W-1:0]    xe_r;
  logic [dti_sa_pkg::T_W-1:0]    t_r;
  logic [dti_sa_pkg::X_W-1:0]    x_r;
  logic [31:0]                   fk_r, fk1_r, fk5_r, v_r;
  logic [31:0]                   itn_r, itn5_r, itn6_r;
  logic [15:0]                   wr_r;
  logic [47:0]                   dprod_r;
  logic [63:0]                   ap_r;
  logic [dti_sa_pkg::A_W-1:0]    a_r;
  logic [dti_sa_pkg::NEXP_STAGES-2:1] big_r;

  logic [dti_sa_pkg::T_W-1:0]       rem;
  logic [dti_sa_pkg::H_W-1:0]       x_nxt;
  logic [dti_sa_pkg::POS_W-1:0]     pos;
  logic [dti_sa_pkg::TAB_IDX_W-1:0] k_idx;
  logic [dti_sa_pkg::TAB_IDX_W-1:0] k1_idx;
  logic [48:0]                      dround;
  logic [63:0]                      around;

  always_comb begin
    rem = {1'b0, plow2_r} - t_r;
    if (rem >= dti_sa_pkg::T_W'(dti_sa_pkg::B_SCALE_X2)) begin
      x_nxt = xe_r + dti_sa_pkg::H_W'(2);
    end else if (rem >= dti_sa_pkg::T_W'(dti_sa_pkg::B_SCALE)) begin
      x_nxt = xe_r + dti_sa_pkg::H_W'(1);
    end else begin
      x_nxt = xe_r;
    end
    pos    = dti_sa_pkg::POS_W'(x_r[15:0]) *
             dti_sa_pkg::POS_W'(dti_sa_pkg::EXP_TABLE_DEPTH);
    k_idx  = pos[dti_sa_pkg::POS_W-1:16];
    k1_idx = k_idx + dti_sa_pkg::TAB_IDX_W'(1);
    dround = 49'(dprod_r) + 49'h8000;
    around = ap_r + (64'd1 << 29);
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      p_r <= dti_sa_pkg::P_W'(qs) * dti_sa_pkg::P_W'(b_value);
    end
    if (stage_en[1]) begin
      big_r[1] <= (p_r >= dti_sa_pkg::EXP_LIMIT);
      plow1_r  <= p_r[dti_sa_pkg::PLOW_W-1:0];
      hm_r     <= dti_sa_pkg::HM_W'(p_r[dti_sa_pkg::PLOW_W-1:dti_sa_pkg::H_LSB]) *
                  dti_sa_pkg::HM_W'(dti_sa_pkg::RECIP);
    end
    if (stage_en[2]) begin
      big_r[2] <= big_r[1];
      plow2_r  <= plow1_r;
      xe_r     <= hm_r[dti_sa_pkg::HM_W-1:dti_sa_pkg::H_W];
      t_r      <= dti_sa_pkg::T_W'(hm_r[dti_sa_pkg::HM_W-1:dti_sa_pkg::H_W]) *
                  dti_sa_pkg::T_W'(dti_sa_pkg::B_SCALE);
    end
    if (stage_en[3]) begin
      big_r[3] <= big_r[2];
      x_r      <= x_nxt[dti_sa_pkg::X_W-1:0];
    end
    if (stage_en[4]) begin
      big_r[4] <= big_r[3];
      fk_r     <= dti_sa_pkg::FRAC_TAB[k_idx];
      fk1_r    <= dti_sa_pkg::FRAC_TAB[k1_idx];
      itn_r    <= dti_sa_pkg::INT_TAB[x_r[dti_sa_pkg::X_W-1:16]];
      wr_r     <= pos[15:0];
    end
    if (stage_en[5]) begin
      big_r[5] <= big_r[4];
      dprod_r  <= 48'(fk_r - fk1_r) * 48'(wr_r);
      fk5_r    <= fk_r;
      itn5_r   <= itn_r;
    end
    if (stage_en[6]) begin
      big_r[6] <= big_r[5];
      v_r      <= fk5_r - dround[47:16];
      itn6_r   <= itn5_r;
    end
    if (stage_en[7]) begin
      big_r[7] <= big_r[6];
      ap_r     <= 64'(itn6_r) * 64'(v_r);
    end
    if (stage_en[8]) begin
      a_r      <= big_r[7] ? '0 : around[30 +: dti_sa_pkg::A_W];
    end
  end

  assign atten = a_r;

endmodule

`default_nettype wire

FILE: rtl/dti_signal_attenuation_core.sv
// Top level: quadratic form pipeline, attenuation, b0 scaling and output stage.
//
//  channel | ports                                | handshake
//  --------+--------------------------------------+----------------
//  in      | in_mask_on in_b0 in_grad_* in_tensor_* | in_valid/in_ready
//  out     | out_signal out_clamped               | out_valid/out_ready
//  cfg     | cfg_index cfg_wdata                  | cfg_we, no wait
//
// One beat per cycle sustained while out_ready is held high.
// Each stage holds its beat while the next one is full and stalled; bubbles close up.
// Reset clears stage valids and loads b_value 1000, scale_by_b0 1.
`default_nettype none

module dti_signal_attenuation_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_mask_on,
  input  wire logic        [15:0]                  in_b0,
  input  wire logic signed [15:0]                  in_grad_x,
  input  wire logic signed [15:0]                  in_grad_y,
  input  wire logic signed [15:0]                  in_grad_z,
  input  wire logic signed [19:0]                  in_tensor_xx,
  input  wire logic signed [19:0]                  in_tensor_xy,
  input  wire logic signed [19:0]                  in_tensor_xz,
  input  wire logic signed [19:0]                  in_tensor_yy,
  input  wire logic signed [19:0]                  in_tensor_yz,
  input  wire logic signed [19:0]                  in_tensor_zz,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic             [31:0]                  out_signal,
  output logic                                     out_clamped,
  input  wire logic                                cfg_we,
  input  wire logic        [dti_sa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [dti_sa_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int NS = dti_sa_pkg::NUM_STAGES;

  logic [dti_sa_pkg::BV_W-1:0] b_value_r;
  logic                        scale_r;

  logic [NS-1:0] v_r;
  logic [NS-1:0] stage_en;

  logic [15:0] b0_r   [NS];
  logic        mask_r [NS];
  logic        neg_r  [NS];

  logic signed [31:0] gxx_r, gyy_r, gzz_r, gxy_r, gxz_r, gyz_r;
  logic signed [19:0] dxx_r, dyy_r, dzz_r, dxy_r, dxz_r, dyz_r;
  logic signed [51:0] txx_r, tyy_r, tzz_r, txy_r, txz_r, tyz_r;
  logic signed [dti_sa_pkg::Q_W-1:0] sdiag_r, soff_r;
  logic signed [dti_sa_pkg::Q_W-1:0] q;
  logic [dti_sa_pkg::QS_W-1:0] qs_r;
  logic [dti_sa_pkg::A_W-1:0]  atten;
  logic [dti_sa_pkg::A_W-1:0]  a_eff;
  logic [dti_sa_pkg::SP_W-1:0] sp_r;
  logic [dti_sa_pkg::SP_W:0]   sround;
  logic [31:0]                 sig_r;
  logic                        clamped_r;

  // Config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_value_r <= dti_sa_pkg::B_VALUE_RESET;
      scale_r   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        dti_sa_pkg::REG_B_VALUE:     b_value_r <= cfg_wdata[dti_sa_pkg::BV_W-1:0];
        dti_sa_pkg::REG_SCALE_BY_B0: scale_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when empty or when its successor loads
  always_comb begin
    stage_en[NS-1] = !v_r[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      stage_en[i] = !v_r[i] || stage_en[i+1];
    end
  end

  assign in_ready = stage_en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (stage_en[i]) begin
          v_r[i] <= (i == 0) ? in_valid : v_r[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  // Sideband travels with each beat
  genvar gi;
  generate
    for (gi = 0; gi < NS; gi++) begin : g_side
      if (gi == 0) begin : g_head
        always_ff @(posedge clk) begin
          if (stage_en[0]) begin
            b0_r[0]   <= in_b0;
            mask_r[0] <= in_mask_on;
            neg_r[0]  <= 1'b0;
          end
        end
      end else if (gi == dti_sa_pkg::NEG_STAGE) begin : g_neg
        always_ff @(posedge clk) begin
          if (stage_en[gi]) begin
            b0_r[gi]   <= b0_r[gi-1];
            mask_r[gi] <= mask_r[gi-1];
            neg_r[gi]  <= q[dti_sa_pkg::Q_W-1];
          end
        end
      end else begin : g_mid
        always_ff @(posedge clk) begin
          if (stage_en[gi]) begin
            b0_r[gi]   <= b0_r[gi-1];
            mask_r[gi] <= mask_r[gi-1];
            neg_r[gi]  <= neg_r[gi-1];
          end
        end
      end
    end
  endgenerate

  // Quadratic form g'Dg
  assign q = sdiag_r + (soff_r <<< 1);

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      gxx_r <= in_grad_x * in_grad_x;
      gyy_r <= in_grad_y * in_grad_y;
      gzz_r <= in_grad_z * in_grad_z;
      gxy_r <= in_grad_x * in_grad_y;
      gxz_r <= in_grad_x * in_grad_z;
      gyz_r <= in_grad_y * in_grad_z;
      dxx_r <= in_tensor_xx;
      dyy_r <= in_tensor_yy;
      dzz_r <= in_tensor_zz;
      dxy_r <= in_tensor_xy;
      dxz_r <= in_tensor_xz;
      dyz_r <= in_tensor_yz;
    end
    if (stage_en[1]) begin
      txx_r <= gxx_r * dxx_r;
      tyy_r <= gyy_r * dyy_r;
      tzz_r <= gzz_r * dzz_r;
      txy_r <= gxy_r * dxy_r;
      txz_r <= gxz_r * dxz_r;
      tyz_r <= gyz_r * dyz_r;
    end
    if (stage_en[2]) begin
      sdiag_r <= dti_sa_pkg::Q_W'(txx_r) + dti_sa_pkg::Q_W'(tyy_r) +
                 dti_sa_pkg::Q_W'(tzz_r);
      soff_r  <= dti_sa_pkg::Q_W'(txy_r) + dti_sa_pkg::Q_W'(txz_r) +
                 dti_sa_pkg::Q_W'(tyz_r);
    end
    if (stage_en[dti_sa_pkg::NEG_STAGE]) begin
      qs_r <= q[dti_sa_pkg::Q_W-1:12];
    end
  end

  dti_sa_nexp u_nexp (
    .clk      (clk),
    .stage_en (stage_en[dti_sa_pkg::MUL_STAGE-1:dti_sa_pkg::NEXP_FIRST]),
    .qs       (qs_r),
    .b_value  (b_value_r),
    .atten    (atten)
  );

  // Negative form clamps attenuation to 1.0
  assign a_eff  = neg_r[dti_sa_pkg::MUL_STAGE-1] ? (dti_sa_pkg::A_W'(1) << 32) : atten;
  assign sround = (dti_sa_pkg::SP_W+1)'(sp_r) + (dti_sa_pkg::SP_W+1)'(16'h8000);

  always_ff @(posedge clk) begin
    if (stage_en[dti_sa_pkg::MUL_STAGE]) begin
      if (scale_r) begin
        sp_r <= dti_sa_pkg::SP_W'(b0_r[dti_sa_pkg::MUL_STAGE-1]) * dti_sa_pkg::SP_W'(a_eff);
      end else begin
        sp_r <= dti_sa_pkg::SP_W'(a_eff);
      end
    end
    if (stage_en[NS-1]) begin
      if (!mask_r[NS-2]) begin
        sig_r     <= {b0_r[NS-2], 16'h0000};
        clamped_r <= 1'b0;
      end else begin
        sig_r     <= (sround[dti_sa_pkg::SP_W:48] != '0) ? 32'hFFFF_FFFF : sround[47:16];
        clamped_r <= neg_r[NS-2];
      end
    end
  end

  assign out_valid   = v_r[NS-1];
  assign out_signal  = sig_r;
  assign out_clamped = clamped_r;

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v_r[0])
    else $error("accepted beat did not enter the first stage");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r))
    else $error("input blocked while the pipeline has a bubble");

  a_clamp_exact: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clamped) |-> (out_signal[15:0] == 16'h0000))
    else $error("clamped beat has a fractional signal");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NS-1] && !out_ready) |=> !stage_en[0] || !v_r[NS-2] || v_r[NS-1])
    else $error("stalled output stage lost its beat");

endmodule

`default_nettype wire

FILE: bench/dti_sa_checker.sv
// Checker: watches the voxel and signal channels, predicts attenuation, compares.
`timescale 1ns / 1ps

module dti_sa_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic               in_mask_on,
  input  wire logic        [15:0] in_b0,
  input  wire logic signed [15:0] in_grad_x,
  input  wire logic signed [15:0] in_grad_y,
  input  wire logic signed [15:0] in_grad_z,
  input  wire logic signed [19:0] in_tensor_xx,
  input  wire logic signed [19:0] in_tensor_xy,
  input  wire logic signed [19:0] in_tensor_xz,
  input  wire logic signed [19:0] in_tensor_yy,
  input  wire logic signed [19:0] in_tensor_yz,
  input  wire logic signed [19:0] in_tensor_zz,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic        [31:0] out_signal,
  input  wire logic               out_clamped,
  input  wire logic               cfg_we,
  input  wire logic        [dti_sa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [dti_sa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    logic [31:0] sig;
    logic        clamped;
  } signal_beat_t;

  logic [63:0]  exp_frac [dti_sa_pkg::EXP_TABLE_DEPTH+1];
  logic [63:0]  exp_int  [dti_sa_pkg::EXP_INT_SPAN];
  logic [14:0]  b_value;
  logic         scale_b0;
  signal_beat_t signal_q [$];

  initial begin
    logic [63:0] term;
    longint      acc;
    for (int k = 0; k <= dti_sa_pkg::EXP_TABLE_DEPTH; k++) begin
      term = 64'd1 << 48;
      acc  = longint'(term);
      for (int i = 1; i <= dti_sa_pkg::SERIES_TERMS; i++) begin
        term = term * 64'(k) / (64'(dti_sa_pkg::EXP_TABLE_DEPTH) * 64'(i));
        if (i % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      exp_frac[k] = (64'(acc) + (64'd1 << 16)) >> 17;
    end
    exp_int[0] = 64'd1 << 31;
    for (int i = 1; i < dti_sa_pkg::EXP_INT_SPAN; i++) begin
      exp_int[i] = (exp_int[i-1] * exp_frac[dti_sa_pkg::EXP_TABLE_DEPTH] +
                    (64'd1 << 30)) >> 31;
    end
  end

  function automatic logic [63:0] attenuation(logic [63:0] x);
    logic [63:0] n, f, pos, k, r, v;
    n = x >> 16;
    f = x & 64'hFFFF;
    if (n >= dti_sa_pkg::EXP_INT_SPAN) begin
      return 64'd0;
    end
    pos = f * dti_sa_pkg::EXP_TABLE_DEPTH;
    k   = pos >> 16;
    r   = pos & 64'hFFFF;
    v   = exp_frac[k] - (((exp_frac[k] - exp_frac[k+1]) * r + 64'h8000) >> 16);
    return (exp_int[n] * v + (64'd1 << 29)) >> 30;
  endfunction

  function automatic signal_beat_t predict_signal();
    signal_beat_t res;
    longint       gx, gy, gz, qf;
    logic [63:0]  a, s;
    res.clamped = 1'b0;
    if (!in_mask_on) begin
      res.sig = {in_b0, 16'h0};
      return res;
    end
    gx = in_grad_x;
    gy = in_grad_y;
    gz = in_grad_z;
    qf = gx * gx * longint'(in_tensor_xx) + gy * gy * longint'(in_tensor_yy)
       + gz * gz * longint'(in_tensor_zz)
       + 2 * (gx * gy * longint'(in_tensor_xy) + gx * gz * longint'(in_tensor_xz)
       + gy * gz * longint'(in_tensor_yz));
    if (qf < 0) begin
      a = 64'd1 << 32;
      res.clamped = 1'b1;
    end else begin
      a = attenuation(((64'(qf) >> 12) * 64'(b_value)) / 64'd1000000);
    end
    if (scale_b0) begin
      s = (64'(in_b0) * a + 64'h8000) >> 16;
    end else begin
      s = (a + 64'h8000) >> 16;
    end
    if (s > 64'hFFFF_FFFF) begin
      s = 64'hFFFF_FFFF;
    end
    res.sig = s[31:0];
    return res;
  endfunction

  assign pending = signal_q.size();

  always @(posedge clk) begin
    signal_beat_t exp_b;
    if (!rst_n) begin
      b_value    <= dti_sa_pkg::B_VALUE_RESET;
      scale_b0   <= 1'b1;
      fail_count <= 0;
      signal_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == dti_sa_pkg::REG_B_VALUE) begin
          b_value <= cfg_wdata[14:0];
        end else if (cfg_index == dti_sa_pkg::REG_SCALE_BY_B0) begin
          scale_b0 <= cfg_wdata[0];
        end
      end
      if (in_valid && in_ready) begin
        signal_q = {signal_q, predict_signal()};
      end
      if (out_valid && out_ready) begin
        if (signal_q.size() == 0) begin
          $display("%0t: unexpected beat signal=%h clamped=%b", $time, out_signal,
                   out_clamped);
          fail_count <= fail_count + 1;
        end else begin
          exp_b = signal_q.pop_front();
          if (exp_b.sig !== out_signal || exp_b.clamped !== out_clamped) begin
            $display("%0t: expected signal=%h clamped=%b, got signal=%h clamped=%b",
                     $time, exp_b.sig, exp_b.clamped, out_signal, out_clamped);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: bench/testbench.sv
// Testbench top: voxel stimulus, config phases, back-pressure and verdict.
`timescale 1ns / 1ps

module testbench;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_mask_on = 1'b0, out_ready = 1'b0, cfg_we = 1'b0;
  logic [15:0] in_b0 = '0;
  logic signed [15:0] in_grad_x = '0, in_grad_y = '0, in_grad_z = '0;
  logic signed [19:0] in_tensor_xx = '0, in_tensor_xy = '0, in_tensor_xz = '0;
  logic signed [19:0] in_tensor_yy = '0, in_tensor_yz = '0, in_tensor_zz = '0;
  logic [dti_sa_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dti_sa_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_ready, out_valid, out_clamped;
  logic [31:0] out_signal;
  int fail_count, pending;
  int cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  dti_signal_attenuation_core u_top (.*);
  dti_sa_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver stalls per beat, with calm stretches
  initial begin
    int wait_n;
    repeat (12) @(posedge clk);
    forever begin
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (wait_n > 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic logic signed [15:0] rand_grad(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'sd16384;
      2: return -16'sd16384;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic signed [19:0] rand_diag(bit wide);
    if (wide) begin
      return 20'($urandom);
    end
    return 20'($urandom_range(0, 3000));
  endfunction

  task automatic send_voxel(logic m, logic [15:0] b, logic signed [15:0] gx,
                            logic signed [15:0] gy, logic signed [15:0] gz,
                            logic signed [19:0] dxx, logic signed [19:0] dxy,
                            logic signed [19:0] dxz, logic signed [19:0] dyy,
                            logic signed [19:0] dyz, logic signed [19:0] dzz,
                            bit gaps);
    int gap_n;
    gap_n = (gaps && $urandom_range(0, 3) != 0) ? $urandom_range(0, 11) : 0;
    if (gap_n > 0) begin
      in_valid <= 1'b0;
      repeat (gap_n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mask_on <= m; in_b0 <= b;
    in_grad_x <= gx; in_grad_y <= gy; in_grad_z <= gz;
    in_tensor_xx <= dxx; in_tensor_xy <= dxy; in_tensor_xz <= dxz;
    in_tensor_yy <= dyy; in_tensor_yz <= dyz; in_tensor_zz <= dzz;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_and_config(logic [dti_sa_pkg::CFG_IDX_W-1:0] idx,
                                  logic [dti_sa_pkg::CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_voxels(int count);
    int gm;
    bit wide;
    for (int i = 0; i < count; i++) begin
      gm = $urandom_range(0, 3);
      wide = ($urandom_range(0, 4) == 0);
      send_voxel($urandom_range(0, 7) != 0, 16'($urandom),
                 rand_grad(gm), rand_grad(gm), rand_grad(gm),
                 rand_diag(wide), wide ? 20'($urandom) : 20'($urandom_range(0, 600)),
                 wide ? 20'($urandom) : 20'($urandom_range(0, 600)), rand_diag(wide),
                 wide ? 20'($urandom) : 20'($urandom_range(0, 600)), rand_diag(wide),
                 $urandom_range(0, 2) != 0);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: masked, extremes, zero, negative, huge exponent
    send_voxel(0, 16'hFFFF, '0, '0, '0, '0, '0, '0, '0, '0, '0, 0);
    send_voxel(0, 16'h0000, 16'sh7FFF, 16'sh8000, '0, '1, '1, '1, '1, '1, '1, 0);
    send_voxel(1, 16'hFFFF, '0, '0, '0, '0, '0, '0, '0, '0, '0, 0);
    send_voxel(1, 16'hFFFF, 16'sd16384, '0, '0, 20'sd700, '0, '0, '0, '0, '0, 0);
    send_voxel(1, 16'd1000, 16'sd16384, '0, '0, -20'sd500, '0, '0, '0, '0, '0, 0);
    send_voxel(1, 16'hFFFF, 16'sh8000, 16'sh8000, 16'sh8000, 20'sh7FFFF, 20'sh7FFFF,
               20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 0);
    send_voxel(1, 16'h5555, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 20'sh80000, 20'sh80000,
               20'sh80000, 20'sh80000, 20'sh80000, 20'sh80000, 0);
    send_voxel(1, 16'hAAAA, 16'sd9459, 16'sd9459, -16'sd9459, 20'sd1700, 20'sd100,
               -20'sd200, 20'sd400, 20'sd50, 20'sd300, 0);
    send_voxel(1, 16'd1, -16'sd16384, 16'sd16384, 16'sd16384, 20'sd3000, 20'sd0,
               20'sd0, 20'sd3000, 20'sd0, 20'sd3000, 0);
    random_voxels(120);
    drain_and_config(dti_sa_pkg::REG_SCALE_BY_B0, 15'd0);
    send_voxel(1, 16'hFFFF, 16'sd16384, '0, '0, -20'sd1, '0, '0, '0, '0, '0, 0);
    send_voxel(0, 16'hFFFF, '0, '0, '0, '0, '0, '0, '0, '0, '0, 0);
    random_voxels(120);
    drain_and_config(dti_sa_pkg::REG_B_VALUE, 15'd0);
    random_voxels(80);
    drain_and_config(dti_sa_pkg::REG_B_VALUE, 15'h7FFF);
    random_voxels(100);
    drain_and_config(dti_sa_pkg::REG_SCALE_BY_B0, 15'h7FFF);
    drain_and_config(dti_sa_pkg::REG_B_VALUE, 15'd20000);
    random_voxels(100);
    drain_and_config(4'hF, 15'd5);
    drain_and_config(dti_sa_pkg::REG_B_VALUE, 15'($urandom_range(1, 3000)));
    random_voxels(80);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

FILE: dti_signal_attenuation_core.f
rtl/dti_sa_pkg.sv
rtl/dti_sa_nexp.sv
rtl/dti_signal_attenuation_core.sv
bench/dti_sa_checker.sv
bench/testbench.sv
